// File: rtl/pesp_pkg.sv
// shared types, register codes, reset values and saturation helper
// for the particle euler step core; no dependencies
package pesp_pkg;

	localparam int DIV_BITS = 4;

	localparam logic [2:0] REG_GRAVITY  = 3'd0;
	localparam logic [2:0] REG_DENSITY  = 3'd1;
	localparam logic [2:0] REG_BOUNCE   = 3'd2;
	localparam logic [2:0] REG_SIZE     = 3'd3;
	localparam logic [2:0] REG_NORMAL_X = 3'd4;
	localparam logic [2:0] REG_NORMAL_Y = 3'd5;
	localparam logic [2:0] REG_NORMAL_Z = 3'd6;
	localparam logic [2:0] REG_OFFSET   = 3'd7;

	localparam logic [30:0] RST_GRAVITY = 31'd655;
	localparam logic [30:0] RST_DENSITY = 31'd39322;
	localparam logic [30:0] RST_BOUNCE  = 31'd65536;
	localparam logic [30:0] RST_SIZE    = 31'd32768;
	localparam logic [31:0] OFF_DISABLED = 32'h8000_0000;

	typedef struct packed {
		logic [2:0][31:0] p;
		logic [2:0][31:0] v;
		logic [20:0]      mass;
		logic [20:0]      dt;
		logic [18:0]      life;
		logic             died;
	} item_t;

	function automatic logic signed [31:0] sat32(input logic signed [71:0] x);
		if (x > 72'sd2147483647) begin
			return 32'sh7fff_ffff;
		end else if (x < -72'sd2147483648) begin
			return 32'sh8000_0000;
		end else begin
			return $signed(x[31:0]);
		end
	endfunction

endpackage

// File: rtl/pesp_div.sv
// pipelined restoring divider, DIV_BITS quotient bits per stage
// depends on pesp_pkg
module pesp_div #(
	parameter int DW = 48,
	parameter int MW = 21
) (
	input  logic          clk,
	input  logic          en,
	input  logic [DW-1:0] num,
	input  logic [MW-1:0] den,
	output logic [DW-1:0] quo
);

	localparam int BPS = pesp_pkg::DIV_BITS;
	localparam int NST = (DW + BPS - 1) / BPS;
	localparam int PW  = NST * BPS;
	localparam int RW  = MW + 1;

	logic [PW-1:0] num_r [NST-1];
	logic [RW-1:0] rem_r [NST-1];
	logic [MW-1:0] den_r [NST-1];
	logic [PW-1:0] quo_r [NST];

	for (genvar i = 0; i < NST; i++) begin : g_st
		logic [PW-1:0] n_in, q_in, n_nx, q_nx;
		logic [RW-1:0] r_in, r_nx;
		logic [MW-1:0] d_in;

		if (i == 0) begin : g_first
			assign n_in = PW'(num);
			assign q_in = '0;
			assign r_in = '0;
			assign d_in = den;
		end else begin : g_rest
			assign n_in = num_r[i-1];
			assign q_in = quo_r[i-1];
			assign r_in = rem_r[i-1];
			assign d_in = den_r[i-1];
		end

		always_comb begin
			n_nx = n_in;
			q_nx = q_in;
			r_nx = r_in;
			for (int b = 0; b < BPS; b++) begin
				r_nx = {r_nx[RW-2:0], n_nx[PW-1]};
				n_nx = {n_nx[PW-2:0], 1'b0};
				if (r_nx >= {1'b0, d_in}) begin
					r_nx = r_nx - {1'b0, d_in};
					q_nx = {q_nx[PW-2:0], 1'b1};
				end else begin
					q_nx = {q_nx[PW-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				quo_r[i] <= q_nx;
			end
		end

		if (i < NST - 1) begin : g_keep
			always_ff @(posedge clk) begin
				if (en) begin
					num_r[i] <= n_nx;
					rem_r[i] <= r_nx;
					den_r[i] <= d_in;
				end
			end
		end
	end

	assign quo = quo_r[NST-1][DW-1:0];

endmodule

// File: rtl/particle_euler_step_plane_bounce_core.sv
// particle euler step with one bouncing plane, signed fixed point
// pipeline of force, divider and collision stages; one request per cycle
// sustained while m_axis_tready does not stall the output
// reset clears all pipeline valid bits and loads the register defaults
// depends on pesp_pkg and pesp_div
module particle_euler_step_plane_bounce_core #(
	parameter int FRAC_BITS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, mass, life_in, fade, time_step
	input  logic [271:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y, new_vel_z, life_out, died
	output logic [215:0] m_axis_tdata,
	input  logic         cfg_we,
	input  logic [2:0]   cfg_index,
	input  logic [31:0]  cfg_data
);

	localparam int DW  = 32 + FRAC_BITS;
	localparam int NST = (DW + pesp_pkg::DIV_BITS - 1) / pesp_pkg::DIV_BITS;
	localparam logic signed [52:0] THRESH = 53'((((2 << FRAC_BITS) + 5) / 10));

	logic [30:0] grav_q, dens_q, bounce_q, size_q;
	logic signed [17:0] nrm_q [3];
	logic signed [31:0] off_q;

	logic adv;
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8;
	logic vld_s9, vld_s10, vld_s11, vld_s12, vld_s13;
	logic vld_dl [NST];

	pesp_pkg::item_t c_in, c_s1, c_s2, c_s3, c_s4, c_s5, c_s6, c_s7, c_s8;
	pesp_pkg::item_t c_s9, c_s10, c_s11, c_s12, c_s13;
	pesp_pkg::item_t c_dl [NST];
	logic neg_dl [NST];

	assign adv = m_axis_tready || !vld_s13;
	assign s_axis_tready = adv;
	assign m_axis_tvalid = vld_s13;

	// config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grav_q   <= pesp_pkg::RST_GRAVITY;
			dens_q   <= pesp_pkg::RST_DENSITY;
			bounce_q <= pesp_pkg::RST_BOUNCE;
			size_q   <= pesp_pkg::RST_SIZE;
			nrm_q[0] <= '0;
			nrm_q[1] <= '0;
			nrm_q[2] <= '0;
			off_q    <= pesp_pkg::OFF_DISABLED;
		end else if (cfg_we) begin
			unique case (cfg_index)
				pesp_pkg::REG_GRAVITY:  grav_q   <= cfg_data[30:0];
				pesp_pkg::REG_DENSITY:  dens_q   <= cfg_data[30:0];
				pesp_pkg::REG_BOUNCE:   bounce_q <= cfg_data[30:0];
				pesp_pkg::REG_SIZE:     size_q   <= cfg_data[30:0];
				pesp_pkg::REG_NORMAL_X: nrm_q[0] <= $signed(cfg_data[17:0]);
				pesp_pkg::REG_NORMAL_Y: nrm_q[1] <= $signed(cfg_data[17:0]);
				pesp_pkg::REG_NORMAL_Z: nrm_q[2] <= $signed(cfg_data[17:0]);
				pesp_pkg::REG_OFFSET:   off_q    <= $signed(cfg_data);
			endcase
		end
	end

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0; vld_s2 <= 1'b0; vld_s3 <= 1'b0; vld_s4 <= 1'b0;
			vld_s5 <= 1'b0; vld_s6 <= 1'b0; vld_s7 <= 1'b0; vld_s8 <= 1'b0;
			vld_s9 <= 1'b0; vld_s10 <= 1'b0; vld_s11 <= 1'b0; vld_s12 <= 1'b0;
			vld_s13 <= 1'b0;
			for (int i = 0; i < NST; i++) begin
				vld_dl[i] <= 1'b0;
			end
		end else if (adv) begin
			vld_s1 <= s_axis_tvalid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_dl[0] <= vld_s4;
			for (int i = 1; i < NST; i++) begin
				vld_dl[i] <= vld_dl[i-1];
			end
			vld_s5 <= vld_dl[NST-1];
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
			vld_s9 <= vld_s8;
			vld_s10 <= vld_s9;
			vld_s11 <= vld_s10;
			vld_s12 <= vld_s11;
			vld_s13 <= vld_s12;
		end
	end

	// stage 1: unpack, volume, gravity force, life
	logic [61:0] vol_prod;
	logic [51:0] grav_prod;
	logic signed [20:0] life_diff;
	logic signed [31:0] vol_n, grav_n;
	logic signed [31:0] vol_s1, grav_s1, grav_s2, grav_s3;

	always_comb begin
		c_in = '0;
		for (int k = 0; k < 3; k++) begin
			c_in.p[k] = s_axis_tdata[32*k +: 32];
			c_in.v[k] = s_axis_tdata[96 + 32*k +: 32];
		end
		c_in.mass = (s_axis_tdata[212:192] == 21'd0) ? 21'd1 : s_axis_tdata[212:192];
		c_in.dt = s_axis_tdata[270:250];
		life_diff = 21'($signed(s_axis_tdata[231:213])) - $signed({3'b0, s_axis_tdata[249:232]});
		c_in.life = (life_diff < -21'sd262144) ? 19'h40000 : life_diff[18:0];
		c_in.died = (life_diff <= 21'sd0);
		vol_prod = 62'(size_q) * 62'(size_q);
		grav_prod = 52'(grav_q) * 52'(c_in.mass);
		vol_n = pesp_pkg::sat32($signed({10'b0, vol_prod >> FRAC_BITS}));
		grav_n = pesp_pkg::sat32($signed({20'b0, grav_prod >> FRAC_BITS}));
	end

	// stages 2 to 4: buoyancy, net force, dividend
	logic signed [63:0] b1_prod, b2_prod;
	logic signed [31:0] buoy1_s2, buoy_s3, force_n;
	logic [31:0] force_mag;
	logic [DW-1:0] num_s4;
	logic neg_s4;

	always_comb begin
		b1_prod = $signed({1'b0, dens_q}) * vol_s1;
		b2_prod = buoy1_s2 * $signed({1'b0, grav_q});
		force_n = pesp_pkg::sat32(72'(buoy_s3) - 72'(grav_s3));
		force_mag = force_n[31] ? 32'(-force_n) : force_n;
	end

	// divider
	logic [DW-1:0] quo;

	pesp_div #(
		.DW(DW),
		.MW(21)
	) u_div (
		.clk (clk),
		.en  (adv),
		.num (num_s4),
		.den (c_s4.mass),
		.quo (quo)
	);

	// stage 5 to 7: acceleration, velocity, position
	logic signed [31:0] acc_s5, acc_n;
	logic signed [53:0] ay_prod;
	logic signed [53:0] px_prod [3];
	pesp_pkg::item_t c6_n, c7_n;

	always_comb begin
		if (neg_dl[NST-1]) begin
			acc_n = ((|quo[DW-1:32]) || (quo[31] && (|quo[30:0]))) ?
				32'sh8000_0000 : $signed(32'(-quo[31:0]));
		end else begin
			acc_n = (|quo[DW-1:31]) ? 32'sh7fff_ffff : $signed(quo[31:0]);
		end
		c6_n = c_s5;
		ay_prod = acc_s5 * $signed({1'b0, c_s5.dt});
		c6_n.v[1] = pesp_pkg::sat32(72'($signed(c_s5.v[1])) + 72'(ay_prod >>> FRAC_BITS));
		c7_n = c_s6;
		for (int k = 0; k < 3; k++) begin
			px_prod[k] = $signed(c_s6.v[k]) * $signed({1'b0, c_s6.dt});
			c7_n.p[k] = pesp_pkg::sat32(72'($signed(c_s6.p[k])) + 72'(px_prod[k] >>> FRAC_BITS));
		end
	end

	// stages 8 to 10: plane distance, normal speed, hit test
	logic signed [49:0] np_prod [3];
	logic signed [49:0] nv_prod [3];
	logic signed [49:0] np_s8 [3];
	logic signed [49:0] ns_s8 [3];
	logic signed [52:0] d_n, d_s9;
	logic signed [51:0] s_n, s_s9;
	logic hit_s9, hit_s10, hit_s11, hit_s12;
	logic signed [31:0] s32_s10;
	logic [52:0] dist_s10;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			np_prod[k] = nrm_q[k] * $signed(c_s7.p[k]);
			nv_prod[k] = nrm_q[k] * $signed(c_s7.v[k]);
		end
		d_n = 53'(np_s8[0]) + 53'(np_s8[1]) + 53'(np_s8[2]) - 53'(off_q);
		s_n = 52'(ns_s8[0]) + 52'(ns_s8[1]) + 52'(ns_s8[2]);
	end

	// stages 11 to 13: reflection and push out
	logic signed [49:0] nvr_prod [3];
	logic signed [71:0] pd_prod [3];
	logic signed [63:0] bv_prod [3];
	logic signed [31:0] nv_s11 [3];
	logic signed [31:0] nv_s12 [3];
	logic signed [71:0] pd_s11 [3];
	logic signed [71:0] pd_s12 [3];
	logic signed [63:0] bv_s12 [3];
	pesp_pkg::item_t c13_n;

	always_comb begin
		c13_n = c_s12;
		for (int k = 0; k < 3; k++) begin
			nvr_prod[k] = s32_s10 * nrm_q[k];
			pd_prod[k] = $signed({1'b0, dist_s10}) * nrm_q[k];
			bv_prod[k] = $signed({1'b0, bounce_q}) * nv_s11[k];
			if (hit_s12) begin
				c13_n.v[k] = pesp_pkg::sat32(72'($signed(c_s12.v[k])) - 72'(nv_s12[k])
					- 72'(bv_s12[k]));
				c13_n.p[k] = pesp_pkg::sat32(72'($signed(c_s12.p[k])) + pd_s12[k]);
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (adv) begin
			c_s1 <= c_in;
			vol_s1 <= vol_n;
			grav_s1 <= grav_n;
			c_s2 <= c_s1;
			buoy1_s2 <= pesp_pkg::sat32(72'(b1_prod >>> FRAC_BITS));
			grav_s2 <= grav_s1;
			c_s3 <= c_s2;
			buoy_s3 <= pesp_pkg::sat32(72'(b2_prod >>> FRAC_BITS));
			grav_s3 <= grav_s2;
			c_s4 <= c_s3;
			num_s4 <= DW'(force_mag) << FRAC_BITS;
			neg_s4 <= force_n[31];
			c_dl[0] <= c_s4;
			neg_dl[0] <= neg_s4;
			for (int i = 1; i < NST; i++) begin
				c_dl[i] <= c_dl[i-1];
				neg_dl[i] <= neg_dl[i-1];
			end
			c_s5 <= c_dl[NST-1];
			acc_s5 <= acc_n;
			c_s6 <= c6_n;
			c_s7 <= c7_n;
			c_s8 <= c_s7;
			for (int k = 0; k < 3; k++) begin
				np_s8[k] <= np_prod[k] >>> FRAC_BITS;
				ns_s8[k] <= nv_prod[k] >>> FRAC_BITS;
			end
			c_s9 <= c_s8;
			d_s9 <= d_n;
			s_s9 <= s_n;
			hit_s9 <= (off_q != $signed(pesp_pkg::OFF_DISABLED)) && (d_n < THRESH)
				&& (53'(s_n) < THRESH);
			c_s10 <= c_s9;
			hit_s10 <= hit_s9;
			s32_s10 <= pesp_pkg::sat32(72'(s_s9));
			dist_s10 <= d_s9[52] ? 53'(-d_s9) : d_s9;
			c_s11 <= c_s10;
			hit_s11 <= hit_s10;
			c_s12 <= c_s11;
			hit_s12 <= hit_s11;
			for (int k = 0; k < 3; k++) begin
				nv_s11[k] <= pesp_pkg::sat32(72'(nvr_prod[k] >>> FRAC_BITS));
				pd_s11[k] <= pd_prod[k] >>> FRAC_BITS;
				nv_s12[k] <= nv_s11[k];
				pd_s12[k] <= pd_s11[k];
				bv_s12[k] <= bv_prod[k] >>> FRAC_BITS;
			end
			c_s13 <= c13_n;
		end
	end

	assign m_axis_tdata = {4'b0, c_s13.died, c_s13.life,
		c_s13.v[2], c_s13.v[1], c_s13.v[0], c_s13.p[2], c_s13.p[1], c_s13.p[0]};

endmodule

// File: tb/tb_particle_euler_step_plane_bounce_core.sv
// testbench for particle_euler_step_plane_bounce_core: streams particles through
// the core under several register settings and checks every result against an
// inline fixed-point predictor; depends on pesp_pkg and the core rtl
`timescale 1ns / 1ps

module tb_particle_euler_step_plane_bounce_core;

	localparam int FRAC = 16;
	localparam longint THRESH = ((longint'(2) << FRAC) + 5) / 10;
	localparam longint S32_MAX = 64'sd2147483647;
	localparam longint S32_MIN = -64'sd2147483648;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 40;

	typedef struct {
		logic [31:0] pos [3];
		logic [31:0] vel [3];
		logic [20:0] mass;
		logic [18:0] life;
		logic [17:0] fade;
		logic [20:0] dt;
	} particle_t;

	typedef struct {
		logic [31:0] pos [3];
		logic [31:0] vel [3];
		logic [18:0] life;
		logic        died;
	} state_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [271:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [215:0] m_axis_tdata;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_index = pesp_pkg::REG_GRAVITY;
	logic [31:0] cfg_data = '0;

	// register mirror
	logic [30:0] r_grav, r_dens, r_bounce, r_size;
	logic [17:0] r_nx, r_ny, r_nz;
	logic [31:0] r_off;

	particle_t pending_q[$];
	state_t    expected_q[$];
	particle_t cur_req;
	string axn [3] = '{"x", "y", "z"};
	int tx_burst = 1, tx_gap = 0, rx_hold = 0;
	logic hold_done = 1'b0;
	int cycles = 0, errors = 0, checked = 0;

	particle_euler_step_plane_bounce_core u_top (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic longint sat(longint x);
		return x > S32_MAX ? S32_MAX : (x < S32_MIN ? S32_MIN : x);
	endfunction

	function automatic longint qmul(longint a, longint b);
		return (a * b) >>> FRAC;
	endfunction

	function automatic state_t euler_bounce(particle_t it);
		longint p[3], v[3], n[3];
		longint g, dens, bnc, sz, off, m, life, vol, buoy, grav, f_net, acc;
		longint d, s, s32, span, nv;
		state_t r;
		g = longint'(r_grav);
		dens = longint'(r_dens);
		bnc = longint'(r_bounce);
		sz = longint'(r_size);
		off = longint'($signed(r_off));
		m = longint'(it.mass);
		if (m == 0) m = 1;
		life = longint'($signed(it.life));
		n[0] = longint'($signed(r_nx));
		n[1] = longint'($signed(r_ny));
		n[2] = longint'($signed(r_nz));
		for (int k = 0; k < 3; k++) begin
			p[k] = longint'($signed(it.pos[k]));
			v[k] = longint'($signed(it.vel[k]));
		end
		vol = sat((sz * sz) >>> FRAC);
		buoy = sat(qmul(dens, vol));
		buoy = sat(qmul(buoy, g));
		grav = sat(qmul(g, m));
		f_net = sat(buoy - grav);
		acc = sat((f_net * (longint'(1) << FRAC)) / m);
		v[1] = sat(v[1] + qmul(acc, longint'(it.dt)));
		for (int k = 0; k < 3; k++) p[k] = sat(p[k] + qmul(v[k], longint'(it.dt)));
		d = -off;
		s = 0;
		for (int k = 0; k < 3; k++) begin
			d += qmul(n[k], p[k]);
			s += qmul(n[k], v[k]);
		end
		if (r_off != pesp_pkg::OFF_DISABLED && d < THRESH && s < THRESH) begin
			s32 = sat(s);
			span = d < 0 ? -d : d;
			for (int k = 0; k < 3; k++) begin
				nv = sat(qmul(s32, n[k]));
				v[k] = sat(v[k] - nv - qmul(bnc, nv));
				p[k] = sat(p[k] + qmul(span, n[k]));
			end
		end
		life = life - longint'(it.fade);
		if (life < -262144) life = -262144;
		for (int k = 0; k < 3; k++) begin
			r.pos[k] = p[k][31:0];
			r.vel[k] = v[k][31:0];
		end
		r.life = life[18:0];
		r.died = (life <= 0);
		return r;
	endfunction

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(0, 4))
			0: return $urandom;
			1: return 32'h7fff_ffff - $urandom_range(0, 3);
			2: return 32'h8000_0000 + $urandom_range(0, 3);
			default: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
		endcase
	endfunction

	function automatic particle_t rand_particle();
		particle_t it;
		for (int k = 0; k < 3; k++) begin
			it.pos[k] = rand_coord();
			it.vel[k] = rand_coord();
		end
		it.mass = ($urandom_range(0, 3) == 0) ? 21'($urandom) : 21'($urandom_range(0, 1048576));
		it.life = 19'($urandom);
		it.fade = ($urandom_range(0, 1) == 0) ? 18'($urandom) : 18'($urandom_range(0, 8192));
		it.dt = ($urandom_range(0, 3) == 0) ? 21'($urandom) : 21'($urandom_range(0, 8192));
		return it;
	endfunction

	function automatic particle_t fill_particle(logic [31:0] pv, logic [20:0] m,
			logic [18:0] l, logic [17:0] f, logic [20:0] t);
		particle_t it;
		for (int k = 0; k < 3; k++) begin
			it.pos[k] = pv;
			it.vel[k] = pv;
		end
		it.mass = m;
		it.life = l;
		it.fade = f;
		it.dt = t;
		return it;
	endfunction

	task automatic add_req(particle_t it);
		pending_q = {pending_q, it};
	endtask

	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		unique case (idx)
			pesp_pkg::REG_GRAVITY:  r_grav = val[30:0];
			pesp_pkg::REG_DENSITY:  r_dens = val[30:0];
			pesp_pkg::REG_BOUNCE:   r_bounce = val[30:0];
			pesp_pkg::REG_SIZE:     r_size = val[30:0];
			pesp_pkg::REG_NORMAL_X: r_nx = val[17:0];
			pesp_pkg::REG_NORMAL_Y: r_ny = val[17:0];
			pesp_pkg::REG_NORMAL_Z: r_nz = val[17:0];
			pesp_pkg::REG_OFFSET:   r_off = val;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_regs(logic [31:0] g, logic [31:0] dn, logic [31:0] b, logic [31:0] sz,
			logic [31:0] nx, logic [31:0] ny, logic [31:0] nz, logic [31:0] off);
		write_reg(pesp_pkg::REG_GRAVITY, g);
		write_reg(pesp_pkg::REG_DENSITY, dn);
		write_reg(pesp_pkg::REG_BOUNCE, b);
		write_reg(pesp_pkg::REG_SIZE, sz);
		write_reg(pesp_pkg::REG_NORMAL_X, nx);
		write_reg(pesp_pkg::REG_NORMAL_Y, ny);
		write_reg(pesp_pkg::REG_NORMAL_Z, nz);
		write_reg(pesp_pkg::REG_OFFSET, off);
	endtask

	task automatic run_and_drain(int n_rand);
		repeat (n_rand) add_req(rand_particle());
		do @(negedge clk);
		while (!(pending_q.size() == 0 && !s_axis_tvalid && expected_q.size() == 0));
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// request driver
	always @(posedge clk) begin
		logic nxt_valid;
		if (arst_n && (!s_axis_tvalid || s_axis_tready)) begin
			if (s_axis_tvalid) expected_q = {expected_q, euler_bounce(cur_req)};
			nxt_valid = 1'b0;
			if (tx_gap > 0) begin
				tx_gap--;
			end else if (pending_q.size() != 0) begin
				cur_req = pending_q.pop_front();
				s_axis_tdata <= {1'b0, cur_req.dt, cur_req.fade, cur_req.life, cur_req.mass,
					cur_req.vel[2], cur_req.vel[1], cur_req.vel[0],
					cur_req.pos[2], cur_req.pos[1], cur_req.pos[0]};
				nxt_valid = 1'b1;
				tx_burst--;
				if (tx_burst <= 0) begin
					tx_burst = $urandom_range(1, 30);
					tx_gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
				end
			end
			s_axis_tvalid <= nxt_valid;
		end
	end

	// result monitor
	always @(posedge clk) begin
		state_t e;
		logic [31:0] act;
		if (arst_n) begin
			cycles++;
			if (cycles == CYCLE_LIMIT) begin
				$display("Verification failed");
				$finish;
			end
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_q.size() == 0) begin
					$error("result with no request pending");
					errors++;
				end else begin
					e = expected_q.pop_front();
					checked++;
					for (int k = 0; k < 3; k++) begin
						act = m_axis_tdata[32*k +: 32];
						if (act !== e.pos[k]) begin
							$error("new_pos_%s exp %h got %h", axn[k], e.pos[k], act);
							errors++;
						end
						act = m_axis_tdata[96 + 32*k +: 32];
						if (act !== e.vel[k]) begin
							$error("new_vel_%s exp %h got %h", axn[k], e.vel[k], act);
							errors++;
						end
					end
					if (m_axis_tdata[210:192] !== e.life) begin
						$error("life_out exp %h got %h", e.life, m_axis_tdata[210:192]);
						errors++;
					end
					if (m_axis_tdata[211] !== e.died) begin
						$error("died exp %b got %b", e.died, m_axis_tdata[211]);
						errors++;
					end
				end
			end
		end
	end

	// receiver stalls
	always @(posedge clk) begin
		if (arst_n) begin
			if (!hold_done && pending_q.size() > 100) begin
				hold_done = 1'b1;
				rx_hold = 300;
			end
			if (rx_hold > 0) begin
				rx_hold--;
				m_axis_tready <= 1'b0;
			end else if ((cycles / 400) % 3 == 0) begin
				m_axis_tready <= 1'b1;
			end else begin
				m_axis_tready <= ($urandom_range(0, 3) != 0);
			end
		end
	end

	initial begin
		r_grav = pesp_pkg::RST_GRAVITY;
		r_dens = pesp_pkg::RST_DENSITY;
		r_bounce = pesp_pkg::RST_BOUNCE;
		r_size = pesp_pkg::RST_SIZE;
		r_nx = '0;
		r_ny = '0;
		r_nz = '0;
		r_off = pesp_pkg::OFF_DISABLED;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset defaults, plane disabled: directed extremes
		add_req(fill_particle('0, '0, '0, '0, '0));
		add_req(fill_particle(32'h7fff_ffff, 21'h1f_ffff, 19'h3_ffff, '0, 21'h1f_ffff));
		add_req(fill_particle(32'h8000_0000, 21'd1, 19'h4_0000, 18'h3_ffff, 21'h1f_ffff));
		add_req(fill_particle(32'h0001_0000, 21'd0, 19'd0, 18'd1, 21'h1_0000));
		add_req(fill_particle(32'hffff_0000, 21'd1048576, 19'd1, 18'd1, 21'd1048576));
		add_req(fill_particle(32'h8000_0000, 21'd0, 19'h4_0000, 18'd131072, 21'd1));
		run_and_drain(80);

		// floor plane y = 0, collisions likely
		set_regs(32'd655, 32'd39322, 32'd65536, 32'd32768, 32'd0, 32'd65536, 32'd0, 32'd0);
		add_req(fill_particle(32'hfff0_0000, 21'd65536, 19'd65536, 18'd100, 21'd6554));
		add_req(fill_particle(32'd0, 21'd65536, 19'd10, 18'd10, 21'd0));
		add_req(fill_particle(32'd13106, 21'd0, 19'd0, 18'd0, 21'd65536));
		add_req(fill_particle(32'h8000_0000, 21'h1f_ffff, 19'h3_ffff, 18'h3_ffff, 21'h1f_ffff));
		run_and_drain(200);

		// extreme gains, negative unit normals, offset at maximum
		set_regs(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
			-32'sd65536, -32'sd65536, -32'sd65536, 32'h7fff_ffff);
		add_req(fill_particle(32'h7fff_ffff, 21'd0, 19'h3_ffff, '0, 21'h1f_ffff));
		add_req(fill_particle(32'h8000_0000, 21'h1f_ffff, '0, 18'h3_ffff, 21'd1));
		run_and_drain(150);

		// zero gains, unnormalized normal, arbitrary offset
		set_regs(32'd0, 32'd0, 32'd0, 32'd0, 32'h0001_ffff, 32'h0002_0000, 32'd12345,
			32'hffff_8000);
		run_and_drain(120);

		// random registers
		for (int ph = 0; ph < 3; ph++) begin
			set_regs($urandom_range(0, 200000), $urandom, $urandom_range(0, 131072),
				$urandom_range(0, 200000), $urandom_range(0, 131072) - 65536,
				$urandom_range(0, 131072) - 65536, $urandom, $urandom_range(0, 524288) - 262144);
			run_and_drain(65);
		end

		$display("checked %0d particle results over 7 register settings, %0d mismatches",
			checked, errors);
		$display("bursty sender, random and long receiver stalls, drains between settings");
		if (errors == 0 && expected_q.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

// File: files.f
rtl/pesp_pkg.sv
rtl/pesp_div.sv
rtl/particle_euler_step_plane_bounce_core.sv
tb/tb_particle_euler_step_plane_bounce_core.sv
